/* design/fpa_pkg.sv */
// shared types, constants and helpers for the fixed-point alu
package fpa_pkg;

	localparam int FRACTION_BITS = 8;
	// numerator width of the divider: magnitude of a shifted up by the fraction bits
	localparam int NUM_W = 32 + FRACTION_BITS;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

	localparam logic [31:0] RAW_MAX = 32'h7fff_ffff;
	localparam logic [31:0] RAW_MIN = 32'h8000_0000;
	localparam logic [31:0] ONE_LSB = 32'h0000_0001;

	typedef enum logic [3:0] {
		CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV, CMD_GT, CMD_LT, CMD_GE, CMD_LE,
		CMD_EQ, CMD_NE, CMD_MIN, CMD_MAX, CMD_INC, CMD_DEC, CMD_FROMINT, CMD_TOINT
	} cmd_e;

	// classified item handed from the front to the back
	typedef struct packed {
		cmd_e        cmd;
		logic [31:0] a;
		logic [31:0] b;
		logic        neg;
		logic [31:0] mag_a;
		logic [31:0] mag_b;
		logic        b_zero;
	} item_t;

	typedef struct packed {
		logic [31:0] v;
		logic        ovf;
	} sat_t;

	// clamp a signed magnitude to 32 raw bits
	function automatic sat_t saturate(logic neg, logic [63:0] mag);
		sat_t r;
		logic [63:0] limit;
		limit = neg ? 64'h0000_0000_8000_0000 : 64'h0000_0000_7fff_ffff;
		if (mag > limit) begin
			r.ovf = 1'b1;
			r.v = neg ? RAW_MIN : RAW_MAX;
		end else begin
			r.ovf = 1'b0;
			r.v = neg ? (32'd0 - mag[31:0]) : mag[31:0];
		end
		return r;
	endfunction

endpackage

/* design/fpa_front.sv */
// front end: takes items, classifies operands, queues them for the back end
module fpa_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [3:0]          command,
	input  logic signed [31:0]  operand_a,
	input  logic signed [31:0]  operand_b,
	output logic                head_valid,
	output fpa_pkg::item_t      head_item,
	input  logic                head_pop
);
	import fpa_pkg::*;

	item_t              queue_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]  wr_ptr_q;
	logic [QPTR_W-1:0]  rd_ptr_q;
	logic [QCNT_W-1:0]  cnt_q;
	item_t              new_item;
	logic               push;
	logic               pop;

	always_comb begin
		new_item.cmd = cmd_e'(command);
		new_item.a = operand_a;
		new_item.b = operand_b;
		new_item.neg = operand_a[31] ^ operand_b[31];
		new_item.mag_a = operand_a[31] ? (32'd0 - operand_a) : operand_a;
		new_item.mag_b = operand_b[31] ? (32'd0 - operand_b) : operand_b;
		new_item.b_zero = (operand_b == 32'd0);
	end

	assign in_stall = (cnt_q == QCNT_W'(QUEUE_DEPTH));
	assign push = in_valid && !in_stall;
	assign head_valid = (cnt_q != '0);
	assign pop = head_pop && head_valid;
	assign head_item = queue_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			queue_q[wr_ptr_q] <= new_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			cnt_q <= cnt_q + QCNT_W'(push) - QCNT_W'(pop);
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= QCNT_W'(QUEUE_DEPTH)) else $error("queue count past depth");
	a_full_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == QCNT_W'(QUEUE_DEPTH)) |-> in_stall) else $error("full queue not stalling");
	a_empty_no_pop: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == '0) |=> (cnt_q <= QCNT_W'(1))) else $error("count moved from empty");

endmodule

/* design/fpa_back.sv */
// back end: operation pipeline with one divider bit per stage and an output register
module fpa_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                head_valid,
	input  fpa_pkg::item_t      head_item,
	output logic                head_pop,
	output logic                out_valid,
	input  logic                out_stall,
	output logic signed [31:0]  result_value,
	output logic                compare_true,
	output logic                overflowed,
	output logic                divided_by_zero
);
	import fpa_pkg::*;

	localparam int NS = NUM_W;

	typedef struct packed {
		cmd_e              cmd;
		logic              neg;
		logic              dz;
		logic [31:0]       res;
		logic              cmp;
		logic              ovf;
		logic [63:0]       prod;
		logic [31:0]       rem;
		logic [NUM_W-1:0]  num;
		logic [NUM_W-1:0]  quo;
		logic [31:0]       den;
	} stage_t;

	// one restoring division step
	function automatic stage_t div_step(stage_t s);
		stage_t n;
		logic [32:0] t;
		logic        qbit;
		n = s;
		t = {s.rem, s.num[NUM_W-1]};
		qbit = (t >= {1'b0, s.den});
		n.rem = qbit ? 32'(t - {1'b0, s.den}) : t[31:0];
		n.num = {s.num[NUM_W-2:0], 1'b0};
		n.quo = {s.quo[NUM_W-2:0], qbit};
		return n;
	endfunction

	// entry stage: simple ops finish here, multiply starts, divider starts
	function automatic stage_t enter(item_t it);
		stage_t s;
		logic [32:0] sum;
		logic [63:0] wide;
		logic [32:0] bias;
		logic [32:0] biased;
		logic signed [32:0] shifted;
		logic lt;
		logic eq;
		sat_t fr;
		s.cmd = it.cmd;
		s.neg = it.neg;
		s.dz = (it.cmd == CMD_DIV) && it.b_zero;
		s.res = '0;
		s.cmp = 1'b0;
		s.ovf = 1'b0;
		s.prod = 64'(it.mag_a) * 64'(it.mag_b);
		s.rem = '0;
		s.num = {it.mag_a, {FRACTION_BITS{1'b0}}};
		s.quo = '0;
		s.den = it.mag_b;
		lt = ($signed(it.a) < $signed(it.b));
		eq = (it.a == it.b);
		sum = '0;
		case (it.cmd)
			CMD_ADD: sum = {it.a[31], it.a} + {it.b[31], it.b};
			CMD_SUB: sum = {it.a[31], it.a} - {it.b[31], it.b};
			CMD_INC: sum = {it.a[31], it.a} + {1'b0, ONE_LSB};
			CMD_DEC: sum = {it.a[31], it.a} - {1'b0, ONE_LSB};
			default: sum = '0;
		endcase
		wide = {{32{it.a[31]}}, it.a} << FRACTION_BITS;
		fr.ovf = ($signed(wide) > $signed({32'd0, RAW_MAX}))
			|| ($signed(wide) < $signed({32'hffff_ffff, RAW_MIN}));
		fr.v = wide[63] ? RAW_MIN : RAW_MAX;
		bias = it.a[31] ? ((33'd1 << FRACTION_BITS) - 33'd1) : 33'd0;
		biased = {it.a[31], it.a} + bias;
		shifted = $signed(biased) >>> FRACTION_BITS;
		case (it.cmd)
			CMD_ADD, CMD_SUB, CMD_INC, CMD_DEC: begin
				s.ovf = sum[32] ^ sum[31];
				s.res = s.ovf ? (sum[32] ? RAW_MIN : RAW_MAX) : sum[31:0];
			end
			CMD_GT: s.cmp = !lt && !eq;
			CMD_LT: s.cmp = lt;
			CMD_GE: s.cmp = !lt;
			CMD_LE: s.cmp = lt || eq;
			CMD_EQ: s.cmp = eq;
			CMD_NE: s.cmp = !eq;
			CMD_MIN: s.res = lt ? it.a : it.b;
			CMD_MAX: s.res = lt ? it.b : it.a;
			CMD_FROMINT: begin
				s.ovf = fr.ovf;
				s.res = fr.ovf ? fr.v : wide[31:0];
			end
			CMD_TOINT: s.res = shifted[31:0];
			default: begin
			end
		endcase
		return div_step(s);
	endfunction

	// second stage: round the product half away from zero and clamp
	function automatic stage_t mul_finish(stage_t s);
		stage_t n;
		logic [63:0] rounded;
		sat_t r;
		n = s;
		rounded = (s.prod + (64'd1 << (FRACTION_BITS - 1))) >> FRACTION_BITS;
		r = saturate(s.neg, rounded);
		if (s.cmd == CMD_MUL) begin
			n.res = r.v;
			n.ovf = r.ovf;
		end
		return n;
	endfunction

	stage_t             stg_s [NS];
	logic [NS-1:0]      vld_s;
	logic               advance;
	logic               out_valid_q;
	logic [31:0]        res_q;
	logic               cmp_q;
	logic               ovf_q;
	logic               dz_q;
	stage_t             last;
	logic [NUM_W:0]     qmag;
	sat_t               dres;

	assign advance = !(out_valid_q && out_stall);
	assign head_pop = advance && head_valid;

	always_ff @(posedge clk) begin
		if (advance) begin
			stg_s[0] <= enter(head_item);
			stg_s[1] <= mul_finish(div_step(stg_s[0]));
			for (int i = 2; i < NS; i++) begin
				stg_s[i] <= div_step(stg_s[i-1]);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (advance) begin
			vld_s <= {vld_s[NS-2:0], head_valid};
		end
	end

	// quotient rounding: bump when twice the remainder reaches the divisor
	always_comb begin
		last = stg_s[NS-1];
		qmag = {1'b0, last.quo} + (NUM_W+1)'({last.rem, 1'b0} >= {1'b0, last.den});
		dres = saturate(last.neg, 64'(qmag));
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			if (last.cmd == CMD_DIV) begin
				res_q <= last.dz ? 32'd0 : dres.v;
				ovf_q <= last.dz ? 1'b0 : dres.ovf;
			end else begin
				res_q <= last.res;
				ovf_q <= last.ovf;
			end
			cmp_q <= last.cmp;
			dz_q <= last.dz;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= vld_s[NS-1];
		end
	end

	assign out_valid = out_valid_q;
	assign result_value = res_q;
	assign compare_true = cmp_q;
	assign overflowed = ovf_q;
	assign divided_by_zero = dz_q;

	a_dz_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && divided_by_zero) |-> (result_value == 32'd0 && !overflowed))
		else $error("zero divisor item with nonzero result");
	a_cmp_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && compare_true) |-> (result_value == 32'd0 && !overflowed))
		else $error("comparison item with nonzero result");
	a_ovf_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && overflowed) |-> (result_value == RAW_MAX || result_value == RAW_MIN))
		else $error("overflow item not at a bound");
	a_hold_pipe: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |-> !head_pop)
		else $error("pipeline moved while output held");

endmodule

/* design/fixed_point_alu.sv */
// Signed fixed-point alu on 32-bit raw values with FRACTION_BITS fraction bits (Q24.8 by
// default). Items enter through a four-entry queue and run through a pipeline whose length
// is set by the divider, which resolves one quotient bit per stage over 32+FRACTION_BITS
// stages; all commands take the same path, so one item is accepted per cycle while the output
// is not held by out_stall, and results appear in order. Multiply and divide are exact and
// round half away from zero; overflow saturates and sets overflowed, and a zero divisor gives
// 0 with divided_by_zero set.
module fixed_point_alu (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [3:0]         command,
	input  logic signed [31:0] operand_a,
	input  logic signed [31:0] operand_b,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] result_value,
	output logic               compare_true,
	output logic               overflowed,
	output logic               divided_by_zero
);
	import fpa_pkg::*;

	logic  head_valid;
	item_t head_item;
	logic  head_pop;

	fpa_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.command    (command),
		.operand_a  (operand_a),
		.operand_b  (operand_b),
		.head_valid (head_valid),
		.head_item  (head_item),
		.head_pop   (head_pop)
	);

	fpa_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.head_valid      (head_valid),
		.head_item       (head_item),
		.head_pop        (head_pop),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.result_value    (result_value),
		.compare_true    (compare_true),
		.overflowed      (overflowed),
		.divided_by_zero (divided_by_zero)
	);

endmodule
